[sv/hbm_pkg.sv]
package hbm_pkg;

	localparam int BUCKET_COUNT    = 1024;  // power of two
	localparam int WAYS_PER_BUCKET = 4;
	localparam int BUCKET_W        = $clog2(BUCKET_COUNT);
	localparam int KEY_W           = 31;
	localparam int VALUE_W         = 31;
	localparam int READ_W          = 32;

	localparam logic signed [READ_W-1:0] NOT_PRESENT = -32'sd1;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FOUND    = 3'd2,
		ST_ABSENT   = 3'd3,
		ST_REMOVED  = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} way_t;

	typedef way_t [WAYS_PER_BUCKET-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	// outcome of one bucket lookup
	typedef struct packed {
		logic                      write_en;
		row_t                      new_row;
		logic signed [READ_W-1:0]  read_value;
		status_t                   status;
	} lkp_t;

endpackage

[sv/hbm_ram.sv]
module hbm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/hbm_lookup.sv]
module hbm_lookup (
	input  hbm_pkg::row_t                     row,
	input  logic [1:0]                        operation,
	input  logic [hbm_pkg::KEY_W-1:0]         key,
	input  logic [hbm_pkg::VALUE_W-1:0]       new_value,
	output hbm_pkg::lkp_t                     lkp
);

	logic [hbm_pkg::WAYS_PER_BUCKET-1:0] match;
	logic [hbm_pkg::WAYS_PER_BUCKET-1:0] free;
	logic [hbm_pkg::WAYS_PER_BUCKET-1:0] hit_oh;
	logic [hbm_pkg::WAYS_PER_BUCKET-1:0] free_oh;
	logic                                any_hit;
	logic                                any_free;
	logic [hbm_pkg::VALUE_W-1:0]         hit_value;

	always_comb begin
		match     = '0;
		free      = '0;
		hit_value = '0;
		for (int w = 0; w < hbm_pkg::WAYS_PER_BUCKET; w++) begin
			match[w] = row[w].valid && (row[w].key == key);
			free[w]  = !row[w].valid;
		end
		// lowest set bit
		hit_oh   = match & (~match + hbm_pkg::WAYS_PER_BUCKET'(1));
		free_oh  = free & (~free + hbm_pkg::WAYS_PER_BUCKET'(1));
		any_hit  = |match;
		any_free = |free;
		for (int w = 0; w < hbm_pkg::WAYS_PER_BUCKET; w++) begin
			hit_value = hit_value | (hit_oh[w] ? row[w].value : '0);
		end
	end

	always_comb begin
		lkp.write_en   = 1'b0;
		lkp.new_row    = row;
		lkp.read_value = hbm_pkg::NOT_PRESENT;
		lkp.status     = hbm_pkg::ST_ABSENT;
		case (hbm_pkg::op_t'(operation))
			hbm_pkg::OP_PUT: begin
				if (any_hit) begin
					lkp.write_en = 1'b1;
					lkp.status   = hbm_pkg::ST_UPDATED;
					for (int w = 0; w < hbm_pkg::WAYS_PER_BUCKET; w++) begin
						if (hit_oh[w]) begin
							lkp.new_row[w].value = new_value;
						end
					end
				end else if (any_free) begin
					lkp.write_en = 1'b1;
					lkp.status   = hbm_pkg::ST_INSERTED;
					for (int w = 0; w < hbm_pkg::WAYS_PER_BUCKET; w++) begin
						if (free_oh[w]) begin
							lkp.new_row[w].valid = 1'b1;
							lkp.new_row[w].key   = key;
							lkp.new_row[w].value = new_value;
						end
					end
				end else begin
					lkp.status = hbm_pkg::ST_FULL;
				end
			end
			hbm_pkg::OP_GET: begin
				if (any_hit) begin
					lkp.read_value = {1'b0, hit_value};
					lkp.status     = hbm_pkg::ST_FOUND;
				end
			end
			hbm_pkg::OP_REMOVE: begin
				if (any_hit) begin
					lkp.write_en = 1'b1;
					lkp.status   = hbm_pkg::ST_REMOVED;
					for (int w = 0; w < hbm_pkg::WAYS_PER_BUCKET; w++) begin
						if (hit_oh[w]) begin
							lkp.new_row[w].valid = 1'b0;
						end
					end
				end
			end
			default: begin
				// unused code: no-op, reported absent
				lkp.write_en = 1'b0;
			end
		endcase
	end

endmodule

[sv/bucketed_hash_map.sv]
// Bucketed hash map: put, get and remove on 31-bit keys, one response word per
// request word. The bucket is the key modulo BUCKET_COUNT (low key bits); each
// bucket holds WAYS_PER_BUCKET key/value ways in one row of a single row-wide
// RAM, so one read brings the whole bucket. After reset the block runs a
// clearing pass, one row per cycle, with req_stall high. For each request
// the bucket row is read in the accept cycle; then, in the compare cycle,
// all ways are compared in parallel, the row is written back and the
// response is loaded. That read-modify-write of the bucket RAM keeps
// req_stall high until the compare cycle is done, so a new request waits
// for the last one to finish. A response waits in its output register
// while the next request is taken; a request whose response cannot yet be
// loaded waits in the compare cycle. A put into a full bucket is dropped
// with status 5; get returns -1 on a miss, every non-get -1 in read_value.
module bucketed_hash_map (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          operation,
	input  logic [hbm_pkg::KEY_W-1:0]           key,
	input  logic [hbm_pkg::VALUE_W-1:0]         new_value,
	// response channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic signed [hbm_pkg::READ_W-1:0]   read_value,
	output logic [2:0]                          status
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK
	} state_t;

	state_t                              state_q;
	logic [hbm_pkg::BUCKET_W-1:0]        clr_q;
	logic [1:0]                          op_q;
	logic [hbm_pkg::KEY_W-1:0]           key_q;
	logic [hbm_pkg::VALUE_W-1:0]         val_q;
	logic [hbm_pkg::BUCKET_W-1:0]        bucket_q;
	logic                                rsp_valid_q;
	logic signed [hbm_pkg::READ_W-1:0]   read_value_q;
	logic [2:0]                          status_q;

	logic                                accept;
	logic                                rsp_free;
	logic                                done;
	logic [hbm_pkg::BUCKET_W-1:0]        bucket_d;

	logic                                ram_we;
	logic [hbm_pkg::BUCKET_W-1:0]        ram_waddr;
	hbm_pkg::row_t                       ram_wdata;
	hbm_pkg::row_t                       ram_rdata;
	hbm_pkg::lkp_t                       lkp;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	// output register can take a new word this cycle
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	// compare cycle finishes: write back and load the response
	assign done      = (state_q == S_LOOK) && rsp_free;

	// BUCKET_COUNT is a power of two: modulo is the low key bits
	assign bucket_d = hbm_pkg::BUCKET_W'(key % hbm_pkg::KEY_W'(hbm_pkg::BUCKET_COUNT));

	// write port: clearing pass, or write-back of the looked-up row
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = bucket_q;
		ram_wdata = lkp.new_row;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (done) begin
			ram_we = lkp.write_en;
		end
	end

	hbm_ram #(
		.DEPTH (hbm_pkg::BUCKET_COUNT),
		.WIDTH (hbm_pkg::ROW_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (bucket_d),
		.rdata (ram_rdata)
	);

	hbm_lookup u_lookup (
		.row       (ram_rdata),
		.operation (op_q),
		.key       (key_q),
		.new_value (val_q),
		.lkp       (lkp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			op_q         <= '0;
			key_q        <= '0;
			val_q        <= '0;
			bucket_q     <= '0;
			rsp_valid_q  <= 1'b0;
			read_value_q <= hbm_pkg::NOT_PRESENT;
			status_q     <= hbm_pkg::ST_ABSENT;
		end else begin
			// a new word is loaded, or the held one leaves
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == hbm_pkg::BUCKET_W'(hbm_pkg::BUCKET_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q     <= operation;
						key_q    <= key;
						val_q    <= new_value;
						bucket_q <= bucket_d;
						state_q  <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (done) begin
						read_value_q <= lkp.read_value;
						status_q     <= lkp.status;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	// no read of a row in the cycle it is written
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && ram_we))
		else $error("bucket RAM read and write in the same cycle");

	// an accepted word always moves into the compare cycle
	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_LOOK))
		else $error("accepted word did not reach compare cycle");

	// a new response only comes out of a compare cycle
	a_rsp_from_look: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_LOOK))
		else $error("response loaded outside compare cycle");

	// only a hit on get carries a value
	a_read_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q != hbm_pkg::ST_FOUND)) |->
			(read_value_q == hbm_pkg::NOT_PRESENT))
		else $error("value returned without a get hit");

endmodule

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRY_COUNT = hbm_pkg::BUCKET_COUNT * hbm_pkg::WAYS_PER_BUCKET;
	localparam int KEY_W       = hbm_pkg::KEY_W;
	localparam int VALUE_W     = hbm_pkg::VALUE_W;
	localparam int READ_W      = hbm_pkg::READ_W;
	localparam int BUCKET_W    = hbm_pkg::BUCKET_W;
	localparam int BUCKETS     = hbm_pkg::BUCKET_COUNT;
	localparam logic [1:0] OP_NOP = 2'd3;   // unused code, block treats it as a no-op
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
	localparam int ITEMS_PER_PHASE = 345;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		logic signed [READ_W-1:0] read_value;
		hbm_pkg::status_t         status;
	} reply_t;

	// Shadow copy of the bucket store plus the queue of replies still owed.
	class kv_scoreboard;
		bit                 way_valid [ENTRY_COUNT];
		logic [KEY_W-1:0]   way_key   [ENTRY_COUNT];
		logic [VALUE_W-1:0] way_value [ENTRY_COUNT];
		reply_t             pending_replies[$];
		int                 errors;

		// apply one accepted request to the shadow store, queue its reply
		function void note_request(logic [1:0] op, logic [KEY_W-1:0] k,
				logic [VALUE_W-1:0] v);
			int     base;
			int     hit;
			int     free_way;
			reply_t r;
			base     = int'(k % BUCKETS) * hbm_pkg::WAYS_PER_BUCKET;
			hit      = -1;
			free_way = -1;
			r.read_value = hbm_pkg::NOT_PRESENT;
			r.status     = hbm_pkg::ST_ABSENT;
			for (int w = 0; w < hbm_pkg::WAYS_PER_BUCKET; w++) begin
				if (way_valid[base + w]) begin
					if (hit < 0 && way_key[base + w] == k)
						hit = w;
				end else if (free_way < 0) begin
					free_way = w;
				end
			end
			case (op)
				hbm_pkg::OP_PUT: begin
					if (hit >= 0) begin
						way_value[base + hit] = v;
						r.status = hbm_pkg::ST_UPDATED;
					end else if (free_way >= 0) begin
						way_valid[base + free_way] = 1'b1;
						way_key[base + free_way]   = k;
						way_value[base + free_way] = v;
						r.status = hbm_pkg::ST_INSERTED;
					end else begin
						r.status = hbm_pkg::ST_FULL;
					end
				end
				hbm_pkg::OP_GET: begin
					if (hit >= 0) begin
						r.read_value = {1'b0, way_value[base + hit]};
						r.status     = hbm_pkg::ST_FOUND;
					end
				end
				hbm_pkg::OP_REMOVE: begin
					if (hit >= 0) begin
						way_valid[base + hit] = 1'b0;
						r.status = hbm_pkg::ST_REMOVED;
					end
				end
				default: ;
			endcase
			pending_replies.push_back(r);
		endfunction

		function void check_response(logic signed [READ_W-1:0] rv, logic [2:0] st);
			reply_t e;
			if (pending_replies.size() == 0) begin
				$display("%0t: response word with none outstanding: read_value %0d status %0d",
					$time, rv, st);
				errors++;
				return;
			end
			e = pending_replies.pop_front();
			if (rv !== e.read_value) begin
				$display("%0t: read_value mismatch: expected %0d actual %0d",
					$time, e.read_value, rv);
				errors++;
			end
			if (st !== e.status) begin
				$display("%0t: status mismatch: expected %0d actual %0d",
					$time, e.status, st);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_replies.size();
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      req_valid;
	logic                      req_stall;
	logic [1:0]                operation;
	logic [KEY_W-1:0]          key;
	logic [VALUE_W-1:0]        new_value;
	logic                      rsp_valid;
	logic                      rsp_stall;
	logic signed [READ_W-1:0]  read_value;
	logic [2:0]                status;

	// idle odds in percent, changed per phase
	int snd_idle;
	int rcv_idle;

	kv_scoreboard sb;

	bucketed_hash_map uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.key        (key),
		.new_value  (new_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_value (read_value),
		.status     (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: random stall, refreshed on each falling edge
	always @(negedge clk) begin
		rsp_stall = ($urandom_range(0, 99) < rcv_idle);
	end

	// response monitor: a word moves when valid is high and we are not stalling
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(read_value, status);
	end

	// Entered right after a falling edge; returns right after the falling edge
	// that follows acceptance, so valid is only ever set once per step.
	task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < snd_idle) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		operation = op;
		key       = k;
		new_value = v;
		@(posedge clk);
		// req_stall stays high through the clearing pass after reset
		while (req_stall)
			@(posedge clk);
		sb.note_request(op, k, v);
		@(negedge clk);
	endtask

	// Mostly a handful of hot buckets with six candidate keys each, so buckets
	// fill, overflow, update and drain; the rest are keys across the whole range.
	task automatic send_random_word();
		logic [1:0]          op;
		logic [KEY_W-1:0]    k;
		logic [BUCKET_W-1:0] bkt;
		int                  pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = hbm_pkg::OP_PUT;
		else if (pick < 75)
			op = hbm_pkg::OP_GET;
		else if (pick < 95)
			op = hbm_pkg::OP_REMOVE;
		else
			op = OP_NOP;
		if ($urandom_range(0, 99) < 80) begin
			if ($urandom_range(0, 1) == 0)
				bkt = BUCKET_W'($urandom_range(0, 5));
			else
				bkt = BUCKET_W'($urandom_range(BUCKETS - 6, BUCKETS - 1));
			k = (KEY_W'($urandom_range(0, 5)) << BUCKET_W) | KEY_W'(bkt);
		end else begin
			k = KEY_W'($urandom());
		end
		send_word(op, k, VALUE_W'($urandom()));
	endtask

	// sender holds off until every owed reply has come back
	task automatic drain();
		req_valid = 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	initial begin
		sb        = new;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		operation = hbm_pkg::OP_PUT;
		key       = '0;
		new_value = '0;
		rsp_stall = 1'b0;
		snd_idle  = 6;
		rcv_idle  = 61;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, all ops, full bucket, lowest free way, no-op code
		send_word(hbm_pkg::OP_PUT, '0, '0);
		send_word(hbm_pkg::OP_GET, '0, VALUE_MAX);
		send_word(hbm_pkg::OP_PUT, KEY_MAX, VALUE_MAX);
		send_word(hbm_pkg::OP_GET, KEY_MAX, '0);
		send_word(hbm_pkg::OP_GET, KEY_W'(BUCKETS - 1), '0);   // same bucket, other key
		send_word(hbm_pkg::OP_PUT, KEY_W'(5), VALUE_W'(11));
		send_word(hbm_pkg::OP_PUT, KEY_W'(5 + BUCKETS), VALUE_W'(22));
		send_word(hbm_pkg::OP_PUT, KEY_W'(5 + 2 * BUCKETS), VALUE_W'(33));
		send_word(hbm_pkg::OP_PUT, KEY_W'(5 + 3 * BUCKETS), VALUE_W'(44));
		send_word(hbm_pkg::OP_PUT, KEY_W'(5 + 4 * BUCKETS), VALUE_W'(55)); // bucket full
		send_word(hbm_pkg::OP_PUT, KEY_W'(5 + BUCKETS), VALUE_W'(66));     // update
		send_word(hbm_pkg::OP_REMOVE, KEY_W'(5 + 2 * BUCKETS), '0);
		send_word(hbm_pkg::OP_REMOVE, KEY_W'(5 + 2 * BUCKETS), '0);       // already gone
		send_word(hbm_pkg::OP_PUT, KEY_W'(5 + 4 * BUCKETS), VALUE_W'(77)); // takes freed way
		send_word(hbm_pkg::OP_GET, KEY_W'(5 + 4 * BUCKETS), '0);
		send_word(hbm_pkg::OP_GET, KEY_W'(5 + 3 * BUCKETS), '0);
		send_word(OP_NOP, KEY_W'(5), VALUE_W'(99));
		send_word(hbm_pkg::OP_GET, KEY_W'(5), '0);
		send_word(hbm_pkg::OP_REMOVE, '0, '0);
		send_word(hbm_pkg::OP_GET, '0, '0);
		send_word(hbm_pkg::OP_PUT, KEY_W'(31'h5555_5555), VALUE_W'(31'h2AAA_AAAA));
		send_word(hbm_pkg::OP_PUT, KEY_W'(31'h2AAA_AAAA), VALUE_W'(31'h5555_5555));
		send_word(hbm_pkg::OP_GET, KEY_W'(31'h5555_5555), '0);
		send_word(hbm_pkg::OP_GET, KEY_W'(31'h2AAA_AAAA), '0);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin snd_idle = 6;  rcv_idle = 61; end
				1: begin snd_idle = 61; rcv_idle = 6;  end
				default: begin snd_idle = 0; rcv_idle = 0; end
			endcase
			repeat (ITEMS_PER_PHASE) send_random_word();
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
